### rtl/core/dvfc_pkg.sv
`default_nettype none

package dvfc_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_WIDTH   = 16;

  localparam int IN_KEY_W = 16;
  localparam int CNT_W    = 16;
  localparam int DCNT_W   = 9;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 80;

  localparam logic [CNT_W-1:0] COUNT_CEIL = '1;

  // output beat field offsets
  localparam int OFS_DCNT   = 0;
  localparam int OFS_MKEY   = 9;
  localparam int OFS_MCNT   = 25;
  localparam int OFS_RKEY   = 41;
  localparam int OFS_RCNT   = 57;
  localparam int OFS_OVF    = 73;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic scan_clr;  // restart table walk
    logic scan_run;  // walk table entries
    logic sum_mode;  // walk builds mode and rarest
    logic upd;       // count hit or append key
    logic publish;   // load result and clear run
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic is_last;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/dvfc_ctrl.sv
`default_nettype none

module dvfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire dvfc_pkg::sts_t sts,
  output dvfc_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEARCH  = 4'b0010,
    ST_UPDATE  = 4'b0100,
    ST_SUMMARY = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.scan_run = 1'b1;
        if (sts.hit || sts.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.upd = 1'b1;
        if (sts.is_last) begin
          cmd.scan_clr = 1'b1;
          state_next   = ST_SUMMARY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SUMMARY: begin
        cmd.scan_run = 1'b1;
        cmd.sum_mode = 1'b1;
        if (sts.scan_done && !sts.out_full) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/dvfc_datapath.sv
`default_nettype none

module dvfc_datapath #(
  parameter int TABLE_DEPTH = dvfc_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = dvfc_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dvfc_pkg::cmd_t              cmd,
  output dvfc_pkg::sts_t                   sts,
  input  wire logic [dvfc_pkg::IN_W-1:0]   s_tdata,
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [dvfc_pkg::OUT_W-1:0]       m_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = (KEY_WIDTH < dvfc_pkg::IN_KEY_W) ? KEY_WIDTH : dvfc_pkg::IN_KEY_W;
  localparam int CW = dvfc_pkg::CNT_W;
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

  logic [KW-1:0] key_mem [TABLE_DEPTH];
  logic [CW-1:0] cnt_mem [TABLE_DEPTH];

  logic [KW-1:0] key_q;
  logic          last_q;
  logic [UW-1:0] used;
  logic          overflow;
  logic [UW-1:0] idx;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic [KW-1:0] rd_key;
  logic [CW-1:0] rd_cnt;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic [CW-1:0] hit_cnt;
  logic [KW-1:0] best_key, least_key;
  logic [CW-1:0] best_cnt, least_cnt;

  logic          issue;
  logic          match;
  logic          key_we, cnt_we;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_cnt;
  logic [UW+dvfc_pkg::DCNT_W-1:0] used_ext;
  logic [KW+dvfc_pkg::IN_KEY_W-1:0] best_key_ext, least_key_ext;

  assign match = rd_pend && !cmd.sum_mode && (rd_key == key_q);
  assign issue = cmd.scan_run && (idx < used) && !hit_found && !match;

  // update write: saturating count on hit, new entry on miss while the table has room
  always_comb begin
    key_we  = 1'b0;
    cnt_we  = 1'b0;
    wr_addr = hit_idx;
    wr_cnt  = (hit_cnt == dvfc_pkg::COUNT_CEIL) ? hit_cnt : hit_cnt + 1'b1;
    if (cmd.upd) begin
      if (hit_found) begin
        cnt_we = 1'b1;
      end else if (used < DEPTH_U) begin
        key_we  = 1'b1;
        cnt_we  = 1'b1;
        wr_addr = used[AW-1:0];
        wr_cnt  = CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (issue) begin
      rd_key <= key_mem[idx[AW-1:0]];
      rd_cnt <= cnt_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      overflow  <= 1'b0;
      rd_pend   <= 1'b0;
      hit_found <= 1'b0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        key_q  <= s_tdata[KW-1:0];
        last_q <= s_tlast;
      end
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= idx[AW-1:0];
        idx    <= idx + 1'b1;
      end
      if (match) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_cnt   <= rd_cnt;
      end
      if (rd_pend && cmd.sum_mode) begin
        if (rd_cnt >= best_cnt) begin
          best_cnt <= rd_cnt;
          best_key <= rd_key;
        end
        if (rd_cnt <= least_cnt) begin
          least_cnt <= rd_cnt;
          least_key <= rd_key;
        end
      end
      if (cmd.upd) begin
        if (!hit_found && used < DEPTH_U) begin
          used <= used + 1'b1;
        end else if (!hit_found) begin
          overflow <= 1'b1;
        end
      end
      if (cmd.scan_clr) begin
        idx       <= '0;
        hit_found <= 1'b0;
        best_cnt  <= '0;
        least_cnt <= dvfc_pkg::COUNT_CEIL;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(dvfc_pkg::OUT_W - dvfc_pkg::OFS_OVF - 1){1'b0}}, overflow,
                     least_cnt, least_key_ext[dvfc_pkg::IN_KEY_W-1:0],
                     best_cnt, best_key_ext[dvfc_pkg::IN_KEY_W-1:0],
                     used_ext[dvfc_pkg::DCNT_W-1:0]};
        used     <= '0;
        overflow <= 1'b0;
      end
    end
  end

  assign used_ext      = {{dvfc_pkg::DCNT_W{1'b0}}, used};
  assign best_key_ext  = {{dvfc_pkg::IN_KEY_W{1'b0}}, best_key};
  assign least_key_ext = {{dvfc_pkg::IN_KEY_W{1'b0}}, least_key};

  assign sts.hit       = hit_found;
  assign sts.scan_done = (idx >= used) && !rd_pend;
  assign sts.is_last   = last_q;
  assign sts.out_full  = m_tvalid;

endmodule

`default_nettype wire

### rtl/core/distinct_value_frequency_counter.sv
// distinct value frequency counter
// counts how often each distinct key occurs in a run of input beats and,
// on the beat marked tlast, returns one summary beat
// input channel  s_*: one key per beat, s_tlast closes the run
// output channel m_*: one summary beat per run, nothing for other beats
// each key walks the stored entries of the run through one registered
// read port of the key and count memories, one entry per cycle; a hit
// bumps the count (saturating at all ones), a miss appends the key, or
// with the table full drops it and flags overflow
// a tlast beat adds a summary walk over all stored entries on that port
// the last entry in table order wins ties for mode and rarest key
// s_tready is high only while the block waits for a key
// the summary sits in an output register; a stalled receiver holds it
// and the block keeps counting the next run, blocking only when a second
// summary is ready before the first was taken
// rst clears entry count, overflow flag and the output valid flag; the
// memories need no clearing, only written entries are ever read
`default_nettype none

module distinct_value_frequency_counter #(
  parameter int TABLE_DEPTH = dvfc_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = dvfc_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // [15:0] key
  input  wire logic [dvfc_pkg::IN_W-1:0] s_tdata,
  input  wire logic                      s_tlast,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // [8:0] distinct_count, [24:9] mode_key, [40:25] mode_count,
  // [56:41] rarest_key, [72:57] rarest_count, [73] table_overflow,
  // [79:74] zero
  output logic [dvfc_pkg::OUT_W-1:0]     m_tdata
);

  dvfc_pkg::cmd_t cmd;
  dvfc_pkg::sts_t sts;

  // sequencer: wait, search, update, summary
  dvfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, walk counter, compare and summary registers
  dvfc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

### rtl/core/dvfc_checker.sv
`default_nettype none

module dvfc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [dvfc_pkg::OUT_W-1:0] m_tdata
);

  // result beat held while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("summary beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("summary beat changed while stalled");

  // no summary right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("summary beat after reset");

  // every stored key was seen at least once
  a_rare_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[dvfc_pkg::OFS_RCNT +: dvfc_pkg::CNT_W] != '0)
    else $error("rarest count is zero");

  a_mode_ge_rare: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[dvfc_pkg::OFS_MCNT +: dvfc_pkg::CNT_W] >=
                 m_tdata[dvfc_pkg::OFS_RCNT +: dvfc_pkg::CNT_W])
    else $error("mode count below rarest count");

endmodule

bind distinct_value_frequency_counter dvfc_checker u_dvfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
